### rtl/core/zone_relay_sequencer_with_duty_timer_unit_assert.svh
// Assertion macros for the zone relay sequencer.
// Included by modules that assert; expects clk and rst_n in scope.
`ifndef ZONE_RELAY_SEQUENCER_WITH_DUTY_TIMER_UNIT_ASSERT_SVH
`define ZONE_RELAY_SEQUENCER_WITH_DUTY_TIMER_UNIT_ASSERT_SVH

// same-cycle implication
`define ZRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ZRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/zrs_pkg.sv
// Package for the zone relay sequencer: constants, register indexes, event codes.
// No dependencies.
package zrs_pkg;

    localparam int ZRS_ZONES      = 4;
    localparam int ZRS_TIMER_BITS = 32;
    localparam int ZRS_ZONE_CAP   = (ZRS_ZONES < 4) ? ZRS_ZONES : 4;

    localparam logic [31:0] ZRS_ZONE_ON_RST     = 32'd30000;
    localparam logic [31:0] ZRS_ZONE_REST_RST   = 32'd600000;
    localparam logic [2:0]  ZRS_ZONE_COUNT_RST  = 3'd1;
    localparam logic [7:0]  ZRS_ZONE_MAP_RST    = 8'd229;
    localparam logic [31:0] ZRS_TOMATO_ON_RST   = 32'd45000;
    localparam logic [31:0] ZRS_TOMATO_REST_RST = 32'd300000;

    typedef enum logic [2:0] {
        ZRS_CFG_ZONE_ON     = 3'd0,
        ZRS_CFG_ZONE_REST   = 3'd1,
        ZRS_CFG_ZONE_COUNT  = 3'd2,
        ZRS_CFG_ZONE_MAP    = 3'd3,
        ZRS_CFG_TOMATO_ON   = 3'd4,
        ZRS_CFG_TOMATO_REST = 3'd5,
        ZRS_CFG_PAUSE       = 3'd6
    } zrs_cfg_idx_t;

    typedef enum logic [1:0] {
        ZRS_EV_NONE = 2'd0,
        ZRS_EV_ON   = 2'd1,
        ZRS_EV_REST = 2'd2
    } zrs_event_t;

endpackage

### rtl/core/zone_relay_sequencer_with_duty_timer_unit.sv
// Zone relay sequencer with tomato duty timer, single-module implementation.
// Depends on zrs_pkg and zone_relay_sequencer_with_duty_timer_unit_assert.svh.
//
// One beat on the input channel is one tick (tick=1 means one millisecond has
// passed). Every accepted beat yields exactly one result beat holding the relay
// outputs after that tick. The block takes one beat per clock cycle: the timer
// compares and state update finish in the accept cycle, and the result sits in
// an output register, so input is stalled only while that register is full
// and the consumer stalls. The result is valid in the cycle after accept.
`include "zone_relay_sequencer_with_duty_timer_unit_assert.svh"

module zone_relay_sequencer_with_duty_timer_unit
    import zrs_pkg::*;
#(
    parameter int TIMER_BITS = ZRS_TIMER_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tick,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  zone_relays,
    output logic        tomato_relay,
    output logic [1:0]  active_zone,
    output logic        resting,
    output logic [1:0]  zone_event,
    output logic        tomato_started
);

    localparam int CMP_W = (TIMER_BITS > 33) ? TIMER_BITS : 33;

    logic [31:0] zone_on_reg;
    logic [31:0] zone_rest_reg;
    logic [2:0]  zone_count_reg;
    logic [7:0]  zone_map_reg;
    logic [31:0] tomato_on_reg;
    logic [31:0] tomato_rest_reg;
    logic        pause_reg;

    logic [TIMER_BITS-1:0] zone_elapsed_reg;
    logic [TIMER_BITS-1:0] zone_elapsed_next;
    logic [TIMER_BITS-1:0] tomato_elapsed_reg;
    logic [TIMER_BITS-1:0] tomato_elapsed_next;
    logic [1:0]            current_zone_reg;
    logic [1:0]            current_zone_next;
    logic                  zone_rest_reg_flag_reg;
    logic                  zone_rest_flag_next;
    logic                  zone_relay_on_reg;
    logic                  zone_relay_on_next;
    logic                  tomato_rest_flag_reg;
    logic                  tomato_rest_flag_next;

    logic [TIMER_BITS-1:0] zone_sat;
    logic [TIMER_BITS-1:0] tomato_sat;
    logic [2:0]            zone_limit;
    logic                  last_zone;
    zrs_event_t            event_next;
    logic                  started_next;
    logic [1:0]            relay_idx;
    logic [3:0]            relays_next;

    logic        accept;
    logic        out_valid_reg;
    logic [3:0]  zone_relays_reg;
    logic        tomato_relay_reg;
    logic [1:0]  active_zone_reg;
    logic        resting_reg;
    zrs_event_t  zone_event_reg;
    logic        tomato_started_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_on_reg     <= ZRS_ZONE_ON_RST;
            zone_rest_reg   <= ZRS_ZONE_REST_RST;
            zone_count_reg  <= ZRS_ZONE_COUNT_RST;
            zone_map_reg    <= ZRS_ZONE_MAP_RST;
            tomato_on_reg   <= ZRS_TOMATO_ON_RST;
            tomato_rest_reg <= ZRS_TOMATO_REST_RST;
            pause_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ZRS_CFG_ZONE_ON:     zone_on_reg     <= cfg_data;
                ZRS_CFG_ZONE_REST:   zone_rest_reg   <= cfg_data;
                ZRS_CFG_ZONE_COUNT:  zone_count_reg  <= cfg_data[2:0];
                ZRS_CFG_ZONE_MAP:    zone_map_reg    <= cfg_data[7:0];
                ZRS_CFG_TOMATO_ON:   tomato_on_reg   <= cfg_data;
                ZRS_CFG_TOMATO_REST: tomato_rest_reg <= cfg_data;
                ZRS_CFG_PAUSE:       pause_reg       <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // saturating elapsed counters
    assign zone_sat   = (zone_elapsed_reg == '1) ? zone_elapsed_reg
                                                 : zone_elapsed_reg + TIMER_BITS'(tick);
    assign tomato_sat = (tomato_elapsed_reg == '1) ? tomato_elapsed_reg
                                                   : tomato_elapsed_reg + TIMER_BITS'(tick);

    always_comb
    begin
        if (zone_count_reg == 3'd0)
            zone_limit = 3'd1;
        else if (zone_count_reg > 3'(ZRS_ZONE_CAP))
            zone_limit = 3'(ZRS_ZONE_CAP);
        else
            zone_limit = zone_count_reg;
    end

    assign last_zone = ({1'b0, current_zone_reg} + 3'd1) >= zone_limit;

    always_comb
    begin
        zone_elapsed_next     = zone_sat;
        tomato_elapsed_next   = tomato_sat;
        current_zone_next     = current_zone_reg;
        zone_rest_flag_next   = zone_rest_reg_flag_reg;
        zone_relay_on_next    = zone_relay_on_reg;
        tomato_rest_flag_next = tomato_rest_flag_reg;
        event_next            = ZRS_EV_NONE;
        started_next          = 1'b0;

        if (pause_reg)
        begin
            zone_relay_on_next = 1'b0;
        end
        else
        begin
            if (!zone_rest_reg_flag_reg)
            begin
                if (CMP_W'(zone_sat) >= CMP_W'(zone_on_reg))
                begin
                    if (last_zone)
                    begin
                        zone_relay_on_next  = 1'b0;
                        zone_rest_flag_next = 1'b1;
                        current_zone_next   = 2'd0;
                        event_next          = ZRS_EV_REST;
                    end
                    else
                    begin
                        current_zone_next  = current_zone_reg + 2'd1;
                        zone_relay_on_next = 1'b1;
                        zone_elapsed_next  = '0;
                        event_next         = ZRS_EV_ON;
                    end
                end
            end
            else if (CMP_W'(zone_sat) >= CMP_W'(zone_on_reg) + CMP_W'(zone_rest_reg))
            begin
                zone_rest_flag_next = 1'b0;
                zone_relay_on_next  = 1'b1;
                zone_elapsed_next   = '0;
                event_next          = ZRS_EV_ON;
            end

            if (tomato_rest_flag_reg &&
                CMP_W'(tomato_sat) >= CMP_W'(tomato_on_reg) + CMP_W'(tomato_rest_reg))
            begin
                tomato_rest_flag_next = 1'b0;
                tomato_elapsed_next   = '0;
                started_next          = 1'b1;
            end
            if (!tomato_rest_flag_next &&
                CMP_W'(tomato_elapsed_next) >= CMP_W'(tomato_on_reg))
            begin
                tomato_rest_flag_next = 1'b1;
                tomato_elapsed_next   = '0;
            end
        end
    end

    assign relay_idx   = zone_map_reg[{current_zone_next, 1'b0} +: 2];
    assign relays_next = zone_relay_on_next ? (4'b0001 << relay_idx) : 4'b0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_elapsed_reg       <= '0;
            tomato_elapsed_reg     <= '0;
            current_zone_reg       <= 2'd0;
            zone_rest_reg_flag_reg <= 1'b0;
            zone_relay_on_reg      <= 1'b1;
            tomato_rest_flag_reg   <= 1'b0;
        end
        else if (accept)
        begin
            zone_elapsed_reg       <= zone_elapsed_next;
            tomato_elapsed_reg     <= tomato_elapsed_next;
            current_zone_reg       <= current_zone_next;
            zone_rest_reg_flag_reg <= zone_rest_flag_next;
            zone_relay_on_reg      <= zone_relay_on_next;
            tomato_rest_flag_reg   <= tomato_rest_flag_next;
        end
    end

    // hold result until taken, load a new beat on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zone_relays_reg    <= relays_next;
            tomato_relay_reg   <= ~tomato_rest_flag_next;
            active_zone_reg    <= current_zone_next;
            resting_reg        <= zone_rest_flag_next;
            zone_event_reg     <= event_next;
            tomato_started_reg <= started_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign zone_relays    = zone_relays_reg;
    assign tomato_relay   = tomato_relay_reg;
    assign active_zone    = active_zone_reg;
    assign resting        = resting_reg;
    assign zone_event     = zone_event_reg;
    assign tomato_started = tomato_started_reg;

    `ZRS_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg, "accepted beat gave no result")
    `ZRS_ASSERT_NOW(a_one_relay, out_valid_reg, $onehot0(zone_relays_reg), "several zone relays on")
    `ZRS_ASSERT_NOW(a_rest_relay_off, out_valid_reg && resting_reg, zone_relays_reg == 4'b0000, "zone relay on while resting")
    `ZRS_ASSERT_NOW(a_rest_event, out_valid_reg && zone_event_reg == ZRS_EV_REST, resting_reg && active_zone_reg == 2'd0, "rest event without rest state")
    `ZRS_ASSERT_NOW(a_on_event, out_valid_reg && zone_event_reg == ZRS_EV_ON, zone_relays_reg != 4'b0000 && !resting_reg, "zone on event with relay off")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for zone_relay_sequencer_with_duty_timer_unit: one tick per beat, one result per beat.
// Predicts every result from a local relay sequencer model. Depends on zrs_pkg and the block RTL.

module tb;
    import zrs_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 1340;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [2:0]  CFG_SPARE    = 3'd7;
    localparam logic [ZRS_TIMER_BITS-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic [3:0] relays;
        logic       tomato;
        logic [1:0] zone;
        logic       rest;
        zrs_event_t ev;
        logic       started;
    } relay_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        tick = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  zone_relays;
    logic        tomato_relay;
    logic [1:0]  active_zone;
    logic        resting;
    logic [1:0]  zone_event;
    logic        tomato_started;

    logic [31:0] zone_on_ms     = ZRS_ZONE_ON_RST;
    logic [31:0] zone_rest_ms   = ZRS_ZONE_REST_RST;
    logic [2:0]  zone_count     = ZRS_ZONE_COUNT_RST;
    logic [7:0]  zone_map       = ZRS_ZONE_MAP_RST;
    logic [31:0] tomato_on_ms   = ZRS_TOMATO_ON_RST;
    logic [31:0] tomato_rest_ms = ZRS_TOMATO_REST_RST;
    logic        pause          = 1'b0;

    logic [ZRS_TIMER_BITS-1:0] zone_ms   = '0;
    logic [ZRS_TIMER_BITS-1:0] tomato_ms = '0;
    logic [1:0]                cur_zone  = 2'd0;
    logic                      zone_resting = 1'b0;
    logic                      zone_lit     = 1'b1;
    logic                      tomato_off   = 1'b0;

    relay_beat_t pending_beats[$];
    int          mismatches = 0;
    int          hold_left = 0;
    bit          calm = 1'b0;
    int unsigned cycle_count = 0;

    zone_relay_sequencer_with_duty_timer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .tick           (tick),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .zone_relays    (zone_relays),
        .tomato_relay   (tomato_relay),
        .active_zone    (active_zone),
        .resting        (resting),
        .zone_event     (zone_event),
        .tomato_started (tomato_started)
    );

    always #6 clk = ~clk;

    function automatic relay_beat_t step_relays(input logic t);
        relay_beat_t b;
        logic [2:0]  last;
        b = '0;
        last = zone_count;
        if (last == 3'd0)
            last = 3'd1;
        if (last > 3'(ZRS_ZONE_CAP))
            last = 3'(ZRS_ZONE_CAP);
        if (zone_ms != TIMER_MAX)
            zone_ms = zone_ms + ZRS_TIMER_BITS'(t);
        if (tomato_ms != TIMER_MAX)
            tomato_ms = tomato_ms + ZRS_TIMER_BITS'(t);
        if (pause)
            zone_lit = 1'b0;
        else
        begin
            if (!zone_resting)
            begin
                if (zone_ms >= zone_on_ms)
                begin
                    if ({1'b0, cur_zone} + 3'd1 >= last)
                    begin
                        zone_lit = 1'b0;
                        zone_resting = 1'b1;
                        cur_zone = 2'd0;
                        b.ev = ZRS_EV_REST;
                    end
                    else
                    begin
                        cur_zone = cur_zone + 2'd1;
                        zone_lit = 1'b1;
                        zone_ms = '0;
                        b.ev = ZRS_EV_ON;
                    end
                end
            end
            else if (64'(zone_ms) >= 64'(zone_on_ms) + 64'(zone_rest_ms))
            begin
                zone_resting = 1'b0;
                zone_lit = 1'b1;
                zone_ms = '0;
                b.ev = ZRS_EV_ON;
            end
            if (tomato_off && 64'(tomato_ms) >= 64'(tomato_on_ms) + 64'(tomato_rest_ms))
            begin
                tomato_off = 1'b0;
                tomato_ms = '0;
                b.started = 1'b1;
            end
            if (!tomato_off && tomato_ms >= tomato_on_ms)
            begin
                tomato_off = 1'b1;
                tomato_ms = '0;
            end
        end
        if (zone_lit)
            b.relays = 4'b0001 << zone_map[{cur_zone, 1'b0} +: 2];
        b.tomato = !tomato_off;
        b.zone = cur_zone;
        b.rest = zone_resting;
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [31:0] pick_period(input int span);
        case ($urandom_range(9, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(span, 1);
        endcase
    endfunction

    task automatic send_tick(input logic t);
        @(negedge clk);
        while (!calm && $urandom_range(99, 0) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tick <= t;
        do
            @(posedge clk);
        while (in_stall);
        pending_beats.push_back(step_relays(t));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ZRS_CFG_ZONE_ON:     zone_on_ms = data;
            ZRS_CFG_ZONE_REST:   zone_rest_ms = data;
            ZRS_CFG_ZONE_COUNT:  zone_count = data[2:0];
            ZRS_CFG_ZONE_MAP:    zone_map = data[7:0];
            ZRS_CFG_TOMATO_ON:   tomato_on_ms = data;
            ZRS_CFG_TOMATO_REST: tomato_rest_ms = data;
            ZRS_CFG_PAUSE:       pause = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic test_after_reset();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_zero_periods();
        wait_idle();
        write_reg(ZRS_CFG_ZONE_ON, 32'd0);
        write_reg(ZRS_CFG_ZONE_REST, 32'd0);
        write_reg(ZRS_CFG_ZONE_COUNT, 32'd4);
        write_reg(ZRS_CFG_ZONE_MAP, 32'h1B);
        write_reg(ZRS_CFG_TOMATO_ON, 32'd0);
        write_reg(ZRS_CFG_TOMATO_REST, 32'd0);
        repeat (6) send_tick(1'b0);
    endtask

    task automatic test_pause_hold();
        wait_idle();
        write_reg(ZRS_CFG_PAUSE, 32'hFFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();
        write_reg(ZRS_CFG_PAUSE, 32'hFFFF_FFFE);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_count_bounds();
        wait_idle();
        write_reg(ZRS_CFG_ZONE_ON, 32'd1);
        write_reg(ZRS_CFG_ZONE_REST, 32'd2);
        write_reg(ZRS_CFG_ZONE_COUNT, 32'd0);
        write_reg(ZRS_CFG_ZONE_MAP, 32'hFF);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();
        write_reg(ZRS_CFG_ZONE_COUNT, 32'hFFFF_FFF7);
        write_reg(ZRS_CFG_ZONE_MAP, 32'hFFFF_FF00);
        repeat (3) send_tick(1'b1);
        wait_idle();
        write_reg(ZRS_CFG_ZONE_COUNT, 32'd2);
        send_tick(1'b1);
    endtask

    task automatic test_wide_sums();
        wait_idle();
        write_reg(ZRS_CFG_ZONE_ON, 32'd1);
        write_reg(ZRS_CFG_ZONE_REST, 32'hFFFF_FFFF);
        write_reg(ZRS_CFG_ZONE_COUNT, 32'd1);
        write_reg(ZRS_CFG_TOMATO_ON, 32'd1);
        write_reg(ZRS_CFG_TOMATO_REST, 32'hFFFF_FFFF);
        repeat (3) send_tick(1'b1);
        wait_idle();
        write_reg(ZRS_CFG_ZONE_ON, 32'hFFFF_FFFF);
        write_reg(ZRS_CFG_ZONE_REST, 32'd1);
        send_tick(1'b1);
    endtask

    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_SPARE, $urandom());
        send_tick(1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(ZRS_CFG_ZONE_ON, 32'd3);
        write_reg(ZRS_CFG_ZONE_REST, 32'd5);
        write_reg(ZRS_CFG_ZONE_COUNT, 32'd3);
        write_reg(ZRS_CFG_ZONE_MAP, $urandom());
        write_reg(ZRS_CFG_TOMATO_ON, 32'd2);
        write_reg(ZRS_CFG_TOMATO_REST, 32'd4);
        write_reg(ZRS_CFG_PAUSE, 32'd0);
        hold_left = HOLD_CYCLES;
        repeat (40) send_tick($urandom_range(99, 0) < 85);
    endtask

    task automatic test_steady_stream();
        wait_idle();
        write_reg(ZRS_CFG_ZONE_ON, 32'd4);
        write_reg(ZRS_CFG_ZONE_REST, 32'd7);
        write_reg(ZRS_CFG_ZONE_COUNT, 32'd4);
        write_reg(ZRS_CFG_ZONE_MAP, $urandom());
        write_reg(ZRS_CFG_TOMATO_ON, 32'd5);
        write_reg(ZRS_CFG_TOMATO_REST, 32'd3);
        calm = 1'b1;
        repeat (150) send_tick($urandom_range(99, 0) < 85);
        calm = 1'b0;
    endtask

    task automatic test_random_phases();
        int          sent;
        int          len;
        logic [31:0] noise;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            noise = $urandom();
            if ($urandom_range(1, 0))
                write_reg(ZRS_CFG_ZONE_ON, pick_period(10));
            if ($urandom_range(1, 0))
                write_reg(ZRS_CFG_ZONE_REST, pick_period(20));
            if ($urandom_range(1, 0))
                write_reg(ZRS_CFG_ZONE_COUNT, $urandom());
            if ($urandom_range(1, 0))
                write_reg(ZRS_CFG_ZONE_MAP, $urandom());
            if ($urandom_range(1, 0))
                write_reg(ZRS_CFG_TOMATO_ON, pick_period(10));
            if ($urandom_range(1, 0))
                write_reg(ZRS_CFG_TOMATO_REST, pick_period(20));
            write_reg(ZRS_CFG_PAUSE, {noise[31:1], $urandom_range(99, 0) < 15});
            len = $urandom_range(60, 15);
            repeat (len) send_tick($urandom_range(99, 0) < 85);
            sent += len;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= !calm && ($urandom_range(99, 0) < 15);
    end

    always @(posedge clk)
    begin : check_beat
        relay_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: result beat with none expected", $time);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("zone_relays", want.relays, zone_relays);
                check_field("tomato_relay", 4'(want.tomato), 4'(tomato_relay));
                check_field("active_zone", 4'(want.zone), 4'(active_zone));
                check_field("resting", 4'(want.rest), 4'(resting));
                check_field("zone_event", 4'(want.ev), 4'(zone_event));
                check_field("tomato_started", 4'(want.started), 4'(tomato_started));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_zero_periods();
        test_pause_hold();
        test_count_bounds();
        test_wide_sums();
        test_spare_index();
        test_backpressure();
        test_steady_stream();
        test_random_phases();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
